[rtl/bbc_pkg.sv]
// Shared types, character codes and decode helpers for the bracket checker.
package bbc_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNEXPECTED = 3'd1,
    ST_MISMATCH   = 3'd2,
    ST_MISSING    = 3'd3,
    ST_CORRECT    = 3'd4,
    ST_OVERFLOW   = 3'd5,
    ST_HALTED     = 3'd6
  } status_t;

  // KIND_NONE marks a byte that is not a bracket of that direction
  typedef enum logic [1:0] {
    KIND_CURLY  = 2'd0,
    KIND_ROUND  = 2'd1,
    KIND_SQUARE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;

  function automatic kind_t opener_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_LCURLY:  k = KIND_CURLY;
      CH_LPAREN:  k = KIND_ROUND;
      CH_LSQUARE: k = KIND_SQUARE;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t closer_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_RCURLY:  k = KIND_CURLY;
      CH_RPAREN:  k = KIND_ROUND;
      CH_RSQUARE: k = KIND_SQUARE;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

[rtl/bracket_balance_checker_core.sv]
// Top level: bracket balance checker with shift-cell stack and output buffer.
//
//  channel | dir | handshake          | content
//  s_*     | in  | s_tvalid/s_tready  | tdata: char_code; tlast: end_of_text
//  m_*     | out | m_tvalid/m_tready  | tdata: status, expected_kind, got_kind,
//          |     |                    |        line_number
//
// One transaction per cycle in while s_tready is high; one registered result
// per transaction. Each accepted transaction does at most one push, pop or
// compare on the top cell of the stack row. Synchronous reset empties the
// stack, clears the counters and sets the line to one; no clearing pass is
// needed. A stalled output fills the second buffer entry, then s_tready drops.
module bracket_balance_checker_core import bbc_pkg::*; #(
  parameter int STACK_DEPTH = 256,
  parameter int LINE_BITS   = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] char_code
  input  logic                s_tlast,   // end_of_text
  output logic                m_tvalid,
  input  logic                m_tready,
  // [2:0] status, [4:3] expected_kind, [6:5] got_kind,
  // [LINE_BITS+6:7] line_number, zero fill above
  output logic [((LINE_BITS+14)/8)*8-1:0] m_tdata
);

  localparam int OUT_W = ((LINE_BITS + 14) / 8) * 8;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic                 accept;
  logic [CNT_W-1:0]     depth;
  logic [CNT_W-1:0]     depth_next;
  logic [CNT_W-1:0]     cnt      [3];
  logic [CNT_W-1:0]     cnt_next [3];
  logic [LINE_BITS-1:0] current_line;
  logic [LINE_BITS-1:0] current_line_next;
  logic                 halted;
  logic                 halted_next;

  stack_op_t            op;
  kind_t                push_kind;
  kind_t                top_kind;
  kind_t                ok;
  kind_t                ck;
  status_t              res_status;
  kind_t                res_exp;
  kind_t                res_got;
  logic [OUT_W-1:0]     res_data;
  logic                 full;

  assign accept = s_tvalid && s_tready;
  assign ok     = opener_kind(s_tdata);
  assign ck     = closer_kind(s_tdata);
  assign full   = (depth == CNT_W'(STACK_DEPTH));

  always_comb begin
    res_status        = ST_OK;
    res_exp           = KIND_CURLY;
    res_got           = KIND_CURLY;
    op                = '0;
    push_kind         = ok;
    depth_next        = depth;
    cnt_next          = cnt;
    halted_next       = halted;
    current_line_next = current_line;

    if (accept) begin
      if (s_tlast) begin
        if (halted) begin
          res_status = ST_HALTED;
        end else if (cnt[0] != '0) begin
          res_status = ST_MISSING;
          res_exp    = KIND_CURLY;
        end else if (cnt[1] != '0) begin
          res_status = ST_MISSING;
          res_exp    = KIND_ROUND;
        end else if (cnt[2] != '0) begin
          res_status = ST_MISSING;
          res_exp    = KIND_SQUARE;
        end else begin
          res_status = ST_CORRECT;
        end
        depth_next        = '0;
        cnt_next          = '{default: '0};
        halted_next       = 1'b0;
        current_line_next = LINE_BITS'(1);
      end else begin
        if (halted) begin
          res_status = ST_HALTED;
        end else if (ok != KIND_NONE) begin
          if (full) begin
            res_status  = ST_OVERFLOW;
            halted_next = 1'b1;
          end else begin
            op.push      = 1'b1;
            depth_next   = depth + CNT_W'(1);
            cnt_next[ok] = cnt[ok] + CNT_W'(1);
          end
        end else if (ck != KIND_NONE) begin
          if (depth == '0) begin
            res_status  = ST_UNEXPECTED;
            res_got     = ck;
            halted_next = 1'b1;
          end else if (top_kind != ck) begin
            res_status  = ST_MISMATCH;
            res_exp     = top_kind;
            res_got     = ck;
            halted_next = 1'b1;
          end else begin
            op.pop     = 1'b1;
            depth_next = depth - CNT_W'(1);
            if (cnt[ck] != '0) begin
              cnt_next[ck] = cnt[ck] - CNT_W'(1);
            end
          end
        end
        // newlines still counted while halted; line saturates
        if (s_tdata == CH_NEWLINE && current_line != '1) begin
          current_line_next = current_line + LINE_BITS'(1);
        end
      end
    end
  end

  always_comb begin
    res_data                = '0;
    res_data[2:0]           = res_status;
    res_data[4:3]           = res_exp;
    res_data[6:5]           = res_got;
    res_data[LINE_BITS+6:7] = current_line;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth        <= '0;
      cnt          <= '{default: '0};
      halted       <= 1'b0;
      current_line <= LINE_BITS'(1);
    end else begin
      depth        <= depth_next;
      cnt          <= cnt_next;
      halted       <= halted_next;
      current_line <= current_line_next;
    end
  end

  bbc_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .op        (op),
    .push_kind (push_kind),
    .top_kind  (top_kind)
  );

  bbc_skid #(
    .WIDTH (OUT_W)
  ) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_data   (res_data),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_ready (m_tready)
  );

  // per-kind counts always add up to the stack depth
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    ({2'b00, cnt[0]} + {2'b00, cnt[1]} + {2'b00, cnt[2]}) == {2'b00, depth})
    else $error("open counts do not match stack depth");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= CNT_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> depth == '0 && !halted && current_line == LINE_BITS'(1))
    else $error("end of text did not clear the checker");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    current_line != '0)
    else $error("line number reached zero");

  a_halt_freezes_stack: assert property (@(posedge clk) disable iff (rst)
    halted && accept && !s_tlast |=> depth == $past(depth))
    else $error("stack moved while halted");

endmodule

[rtl/bbc_cell.sv]
// One stack cell: holds a bracket kind, shifts down on push and up on pop.
module bbc_cell import bbc_pkg::*; (
  input  logic      clk,
  input  stack_op_t op,
  input  kind_t     from_above,
  input  kind_t     from_below,
  output kind_t     kind
);

  always_ff @(posedge clk) begin
    if (op.push) begin
      kind <= from_above;
    end else if (op.pop) begin
      kind <= from_below;
    end
  end

endmodule

[rtl/bbc_stack.sv]
// Shift-register stack built as a row of cells; cell 0 is the top of stack.
module bbc_stack import bbc_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic      clk,
  input  stack_op_t op,
  input  kind_t     push_kind,
  output kind_t     top_kind
);

  kind_t kinds [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    kind_t above;
    kind_t below;

    if (i == 0) begin : g_first
      assign above = push_kind;
    end else begin : g_mid_above
      assign above = kinds[i-1];
    end

    // last cell just holds on pop; its content is past the depth anyway
    if (i == DEPTH - 1) begin : g_last
      assign below = kinds[i];
    end else begin : g_mid_below
      assign below = kinds[i+1];
    end

    bbc_cell u_cell (
      .clk        (clk),
      .op         (op),
      .from_above (above),
      .from_below (below),
      .kind       (kinds[i])
    );
  end

  assign top_kind = kinds[0];

endmodule

[rtl/bbc_skid.sv]
// Two-entry output buffer: registered ready, result held until taken.
module bbc_skid #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_data,
  output logic             in_ready,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data,
  input  logic             out_ready
);

  logic             main_valid;
  logic [WIDTH-1:0] main_data;
  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else if (in_valid) begin
        main_data  <= in_data;
        main_valid <= 1'b1;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (in_valid && !skid_valid) begin
      skid_data  <= in_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

[tb/sv/tb_bracket_balance_checker_core.sv]
// Self-checking testbench for the bracket balance checker: directed table, random texts.
module tb_bracket_balance_checker_core;
  import bbc_pkg::*;

  localparam int          STACK_SLOTS  = 256;
  localparam int          LINE_BITS    = 20;
  localparam int          TDATA_W      = ((LINE_BITS + 14) / 8) * 8;
  localparam logic [19:0] LINE_MAX     = 20'hFFFFF;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          RANDOM_ITEMS = 2000;
  localparam int          DRAIN_LIMIT  = 2000;
  localparam int          NL_RUN       = 40;
  localparam longint      CYCLE_LIMIT  = 4_000_000;

  // text styles for the random part
  localparam int TXT_BALANCED = 0;
  localparam int TXT_UNCLOSED = 1;
  localparam int TXT_BAD_CLOSER = 2;
  localparam int TXT_NOISE = 3;

  typedef struct packed {
    status_t     status;
    kind_t       expk;
    kind_t       gotk;
    logic [19:0] line;
  } verdict_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eot;
    logic       typed;
    verdict_t   v;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eot;
  } char_item_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = 8'h00;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;

  // typed expectation travelling alongside the driven transaction
  logic     row_typed = 1'b0;
  verdict_t row_verdict = '0;

  // predictor state
  kind_t       bracket_stack [STACK_SLOTS];
  int          nest_depth;
  int          open_per_kind [3];
  logic [19:0] line_now;
  logic        halted;

  verdict_t   verdict_q [$];
  dir_row_t   directed [$];
  char_item_t text_chars [$];

  bit     tx_burst = 1'b0;
  bit     rx_burst = 1'b0;
  bit     hold_req = 1'b0;
  int     fails = 0;
  int     results_seen = 0;
  int     random_sent = 0;
  longint cycles = 0;

  bracket_balance_checker_core #(
    .STACK_DEPTH(STACK_SLOTS),
    .LINE_BITS  (LINE_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bracket_balance_checker_core test failed");
      $finish;
    end
  end

  function automatic void clear_checker();
    nest_depth = 0;
    for (int k = 0; k < 3; k++) open_per_kind[k] = 0;
    line_now = 20'd1;
    halted = 1'b0;
  endfunction

  function automatic logic [7:0] opener_char(input kind_t k);
    case (k)
      KIND_CURLY: return CH_LCURLY;
      KIND_ROUND: return CH_LPAREN;
      default:    return CH_LSQUARE;
    endcase
  endfunction

  function automatic logic [7:0] closer_char(input kind_t k);
    case (k)
      KIND_CURLY: return CH_RCURLY;
      KIND_ROUND: return CH_RPAREN;
      default:    return CH_RSQUARE;
    endcase
  endfunction

  function automatic verdict_t predict_verdict(input logic [7:0] c, input logic eot);
    verdict_t v;
    kind_t    ok;
    kind_t    ck;
    v.status = ST_OK;
    v.expk = KIND_CURLY;
    v.gotk = KIND_CURLY;
    v.line = line_now;
    ok = KIND_NONE;
    ck = KIND_NONE;
    case (c)
      CH_LCURLY:  ok = KIND_CURLY;
      CH_LPAREN:  ok = KIND_ROUND;
      CH_LSQUARE: ok = KIND_SQUARE;
      CH_RCURLY:  ck = KIND_CURLY;
      CH_RPAREN:  ck = KIND_ROUND;
      CH_RSQUARE: ck = KIND_SQUARE;
      default: ;
    endcase
    if (eot) begin
      if (halted) begin
        v.status = ST_HALTED;
      end else begin
        v.status = ST_CORRECT;
        // first kind still open wins: curly, round, square
        for (int k = 0; k < 3; k++) begin
          if (v.status == ST_CORRECT && open_per_kind[k] != 0) begin
            v.status = ST_MISSING;
            v.expk = kind_t'(k);
          end
        end
      end
      clear_checker();
    end else begin
      if (halted) begin
        v.status = ST_HALTED;
      end else if (ok != KIND_NONE) begin
        if (nest_depth >= STACK_SLOTS) begin
          v.status = ST_OVERFLOW;
          halted = 1'b1;
        end else begin
          bracket_stack[nest_depth] = ok;
          nest_depth++;
          open_per_kind[ok]++;
        end
      end else if (ck != KIND_NONE) begin
        if (nest_depth == 0) begin
          v.status = ST_UNEXPECTED;
          v.gotk = ck;
          halted = 1'b1;
        end else if (bracket_stack[nest_depth-1] != ck) begin
          v.status = ST_MISMATCH;
          v.expk = bracket_stack[nest_depth-1];
          v.gotk = ck;
          halted = 1'b1;
        end else begin
          nest_depth--;
          open_per_kind[ck]--;
        end
      end
      // newlines count even while halted; line saturates
      if (c == CH_NEWLINE && line_now != LINE_MAX) line_now++;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    fails++;
    if (fails <= 40)
      $display("mismatch at result %0d: %s = %0h, expected %0h", results_seen, what, got, want);
  endtask

  // input and output transactions, the input side handled before the output side
  always @(posedge clk) begin : watch
    verdict_t pred;
    verdict_t exp_v;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pred = predict_verdict(s_tdata, s_tlast);
        verdict_q.push_back(row_typed ? row_verdict : pred);
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          report_mismatch("result with nothing expected", m_tdata, 0);
        end else begin
          exp_v = verdict_q.pop_front();
          if (m_tdata[2:0] !== exp_v.status)
            report_mismatch("status", m_tdata[2:0], exp_v.status);
          if (m_tdata[4:3] !== exp_v.expk)
            report_mismatch("expected_kind", m_tdata[4:3], exp_v.expk);
          if (m_tdata[6:5] !== exp_v.gotk)
            report_mismatch("got_kind", m_tdata[6:5], exp_v.gotk);
          if (m_tdata[26:7] !== exp_v.line)
            report_mismatch("line_number", m_tdata[26:7], exp_v.line);
          if (m_tdata[TDATA_W-1:27] !== '0)
            report_mismatch("zero fill", m_tdata[TDATA_W-1:27], 0);
        end
      end
    end
  end

  function automatic int idle_cycles(input bit burst);
    return burst ? 0 : $urandom_range(0, 13);
  endfunction

  // receiver: random stalls, no-stall stretches, and one long hold on request
  initial begin : sink
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        n = idle_cycles(rx_burst);
      end
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // valid is only lowered when a gap follows, never dropped and raised in one step
  task automatic send_item(input logic [7:0] c, input logic eot, input logic typed,
                           input verdict_t tv);
    int gap;
    gap = idle_cycles(tx_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid    <= 1'b1;
    s_tdata     <= c;
    s_tlast     <= eot;
    row_typed   <= typed;
    row_verdict <= tv;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic add_row(input logic [7:0] c, input logic eot, input logic typed,
                         input status_t st, input kind_t ek, input kind_t gk,
                         input logic [19:0] ln);
    dir_row_t r;
    r.c = c;
    r.eot = eot;
    r.typed = typed;
    r.v.status = st;
    r.v.expk = ek;
    r.v.gotk = gk;
    r.v.line = ln;
    directed.push_back(r);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) return CH_NEWLINE;
    c = 8'($urandom_range(0, 255));
    if (c == CH_LCURLY || c == CH_RCURLY || c == CH_LPAREN || c == CH_RPAREN ||
        c == CH_LSQUARE || c == CH_RSQUARE)
      c = 8'h2E;
    return c;
  endfunction

  function automatic logic [7:0] noise_char();
    kind_t k;
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    k = kind_t'($urandom_range(0, 2));
    return $urandom_range(0, 1) ? opener_char(k) : closer_char(k);
  endfunction

  function automatic void push_char(input logic [7:0] c, input logic eot);
    char_item_t it;
    it.c = c;
    it.eot = eot;
    text_chars.push_back(it);
  endfunction

  task automatic compose_text(input int style);
    kind_t open_k [$];
    kind_t k;
    int    len;
    int    r;
    int    n;
    text_chars.delete();
    len = $urandom_range(0, 40);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (style == TXT_NOISE) begin
        push_char(noise_char(), 1'b0);
      end else if (r < 3 && open_k.size() < 24) begin
        k = kind_t'($urandom_range(0, 2));
        open_k.push_back(k);
        push_char(opener_char(k), 1'b0);
      end else if (r < 6 && open_k.size() != 0) begin
        k = open_k.pop_back();
        push_char(closer_char(k), 1'b0);
      end else begin
        push_char(plain_char(), 1'b0);
      end
    end
    case (style)
      TXT_BALANCED: begin
        while (open_k.size() != 0) push_char(closer_char(open_k.pop_back()), 1'b0);
      end
      TXT_UNCLOSED: begin
        if (open_k.size() == 0) begin
          k = kind_t'($urandom_range(0, 2));
          open_k.push_back(k);
          push_char(opener_char(k), 1'b0);
        end
        n = $urandom_range(0, open_k.size() - 1);
        repeat (n) push_char(closer_char(open_k.pop_back()), 1'b0);
      end
      TXT_BAD_CLOSER: begin
        if (open_k.size() == 0) begin
          push_char(closer_char(kind_t'($urandom_range(0, 2))), 1'b0);
        end else begin
          k = open_k[open_k.size()-1];
          push_char(closer_char(kind_t'((int'(k) + 1 + $urandom_range(0, 1)) % 3)), 1'b0);
        end
        repeat ($urandom_range(0, 5)) push_char(noise_char(), 1'b0);
      end
      default: ;
    endcase
    push_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // fills the stack to the brim; with overflow one opener more goes in
  task automatic deep_text(input bit overflow);
    kind_t open_k [$];
    kind_t k;
    text_chars.delete();
    repeat (STACK_SLOTS) begin
      k = kind_t'($urandom_range(0, 2));
      open_k.push_back(k);
      push_char(opener_char(k), 1'b0);
    end
    if (overflow) begin
      push_char(opener_char(kind_t'($urandom_range(0, 2))), 1'b0);
      repeat ($urandom_range(1, 4)) push_char(noise_char(), 1'b0);
    end else begin
      while (open_k.size() != 0) push_char(closer_char(open_k.pop_back()), 1'b0);
    end
    push_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text();
    foreach (text_chars[i]) begin
      send_item(text_chars[i].c, text_chars[i].eot, 1'b0, '0);
      random_sent++;
    end
  endtask

  initial begin : stimulus
    int  style;
    int  drain;
    bit  overflow_done;
    overflow_done = 1'b0;
    clear_checker();

    //      char        eot   typed status         expected     got          line
    add_row(8'h61,      1'b0, 1'b1, ST_OK,         KIND_CURLY,  KIND_CURLY,  20'd1);
    add_row(CH_RCURLY,  1'b0, 1'b1, ST_UNEXPECTED, KIND_CURLY,  KIND_CURLY,  20'd1);
    add_row(CH_LPAREN,  1'b0, 1'b1, ST_HALTED,     KIND_CURLY,  KIND_CURLY,  20'd1);
    add_row(CH_NEWLINE, 1'b0, 1'b1, ST_HALTED,     KIND_CURLY,  KIND_CURLY,  20'd1);
    add_row(8'h00,      1'b1, 1'b1, ST_HALTED,     KIND_CURLY,  KIND_CURLY,  20'd2);
    add_row(CH_LCURLY,  1'b0, 1'b0, ST_OK,         KIND_CURLY,  KIND_CURLY,  20'd0);
    add_row(CH_LPAREN,  1'b0, 1'b0, ST_OK,         KIND_CURLY,  KIND_CURLY,  20'd0);
    add_row(CH_LSQUARE, 1'b0, 1'b0, ST_OK,         KIND_CURLY,  KIND_CURLY,  20'd0);
    add_row(CH_RSQUARE, 1'b0, 1'b0, ST_OK,         KIND_CURLY,  KIND_CURLY,  20'd0);
    add_row(CH_RCURLY,  1'b0, 1'b1, ST_MISMATCH,   KIND_ROUND,  KIND_CURLY,  20'd1);
    add_row(8'hFF,      1'b1, 1'b1, ST_HALTED,     KIND_CURLY,  KIND_CURLY,  20'd1);
    add_row(CH_LSQUARE, 1'b0, 1'b0, ST_OK,         KIND_CURLY,  KIND_CURLY,  20'd0);
    add_row(CH_RPAREN,  1'b0, 1'b1, ST_MISMATCH,   KIND_SQUARE, KIND_ROUND,  20'd1);
    add_row(8'h00,      1'b1, 1'b1, ST_HALTED,     KIND_CURLY,  KIND_CURLY,  20'd1);
    add_row(CH_LPAREN,  1'b0, 1'b0, ST_OK,         KIND_CURLY,  KIND_CURLY,  20'd0);
    add_row(CH_RPAREN,  1'b0, 1'b0, ST_OK,         KIND_CURLY,  KIND_CURLY,  20'd0);
    add_row(8'h00,      1'b1, 1'b1, ST_CORRECT,    KIND_CURLY,  KIND_CURLY,  20'd1);
    add_row(CH_LCURLY,  1'b0, 1'b0, ST_OK,         KIND_CURLY,  KIND_CURLY,  20'd0);
    add_row(CH_NEWLINE, 1'b0, 1'b0, ST_OK,         KIND_CURLY,  KIND_CURLY,  20'd0);
    add_row(8'hFF,      1'b1, 1'b1, ST_MISSING,    KIND_CURLY,  KIND_CURLY,  20'd2);
    add_row(CH_LSQUARE, 1'b0, 1'b0, ST_OK,         KIND_CURLY,  KIND_CURLY,  20'd0);
    add_row(8'h00,      1'b1, 1'b1, ST_MISSING,    KIND_SQUARE, KIND_CURLY,  20'd1);
    add_row(CH_LPAREN,  1'b0, 1'b0, ST_OK,         KIND_CURLY,  KIND_CURLY,  20'd0);
    add_row(8'h00,      1'b1, 1'b1, ST_MISSING,    KIND_ROUND,  KIND_CURLY,  20'd1);
    add_row(CH_RSQUARE, 1'b0, 1'b1, ST_UNEXPECTED, KIND_CURLY,  KIND_SQUARE, 20'd1);
    add_row(8'h00,      1'b1, 1'b1, ST_HALTED,     KIND_CURLY,  KIND_CURLY,  20'd1);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_item(directed[i].c, directed[i].eot, directed[i].typed, directed[i].v);

    // long receiver hold while the sender keeps pushing: buffer fills, s_tready drops
    hold_req = 1'b1;
    tx_burst = 1'b1;
    deep_text(1'b0);
    send_text();
    tx_burst = 1'b0;

    while (random_sent < RANDOM_ITEMS) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      rx_burst = ($urandom_range(0, 4) == 0);
      if (!overflow_done && random_sent > RANDOM_ITEMS / 2) begin
        overflow_done = 1'b1;
        deep_text(1'b1);
      end else begin
        style = $urandom_range(0, 9);
        if (style < 6)       compose_text(TXT_BALANCED);
        else if (style == 6) compose_text(TXT_UNCLOSED);
        else if (style == 7) compose_text(TXT_BAD_CLOSER);
        else                 compose_text(TXT_NOISE);
      end
      send_text();
    end

    // a run of newlines back to back, then a short balanced text
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    repeat (NL_RUN) send_item(CH_NEWLINE, 1'b0, 1'b0, '0);
    send_item(CH_LPAREN, 1'b0, 1'b0, '0);
    send_item(CH_RPAREN, 1'b0, 1'b0, '0);
    send_item(8'h00, 1'b1, 1'b1, '{ST_CORRECT, KIND_CURLY, KIND_CURLY, 20'(NL_RUN + 1)});
    s_tvalid <= 1'b0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;

    drain = 0;
    while (verdict_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    if (verdict_q.size() != 0)
      report_mismatch("results never delivered", verdict_q.size(), 0);
    repeat (8) @(posedge clk);

    if (fails == 0) begin
      $display("bracket_balance_checker_core test passed");
    end else begin
      $display("bracket_balance_checker_core test failed");
    end
    $finish;
  end

endmodule
